// ===== design/bci_pkg.sv =====
// Shared types, constants and field widths of the breakpoint curve interpolator.
package bci_pkg;

    // Field widths of the input and result words.
    localparam int CURVE_W = 4;
    localparam int BANK_W  = 2;
    localparam int SLOT_W  = 5;
    localparam int WORD_W  = 32;
    localparam int LEVEL_W = 7;

    // Default store geometry.
    localparam int DEF_NUM_BANKS       = 4;
    localparam int DEF_CURVES_PER_BANK = 12;
    localparam int DEF_NUM_POINTS      = 9;

    // Widest store address over the whole parameter range (16 x 16 x 32 words).
    localparam int ADDR_W_MAX = 13;

    // Largest result level.
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'h7F;

    // Word kinds.
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // One classified word between the front and the back.
    typedef struct packed {
        logic                  is_lookup;
        logic                  in_range;
        logic [ADDR_W_MAX-1:0] addr;
        logic [WORD_W-1:0]     data;
    } entry_t;

endpackage

// ===== design/bci_if.sv =====
// Handshake interfaces for the lookup/write words and the result words.
interface bci_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [bci_pkg::CURVE_W-1:0]  curve_select;
    logic [bci_pkg::BANK_W-1:0]   bank_select;
    logic [bci_pkg::SLOT_W-1:0]   point_slot;
    logic signed [bci_pkg::WORD_W-1:0] table_word;
    logic signed [bci_pkg::WORD_W-1:0] position;

    modport source (output valid, kind, curve_select, bank_select, point_slot,
                    table_word, position, input ready);
    modport sink (input valid, kind, curve_select, bank_select, point_slot,
                  table_word, position, output ready);
endinterface

interface bci_out_if;
    logic                         valid;
    logic                         ready;
    logic [bci_pkg::LEVEL_W-1:0]  level;
    logic                         divide_fault;

    modport source (output valid, level, divide_fault, input ready);
    modport sink (input valid, level, divide_fault, output ready);
endinterface

// ===== design/bci_front.sv =====
// Front end: accepts words, checks their range and forms the store address.
module bci_front #(
    parameter int NUM_BANKS       = bci_pkg::DEF_NUM_BANKS,
    parameter int CURVES_PER_BANK = bci_pkg::DEF_CURVES_PER_BANK,
    parameter int NUM_POINTS      = bci_pkg::DEF_NUM_POINTS
) (
    bci_in_if.sink          in_w,
    input  logic            q_full,
    output logic            push,
    output bci_pkg::entry_t push_entry
);
    import bci_pkg::*;

    localparam int CURVE_WORDS = 2 * NUM_POINTS;

    logic                  bank_ok;
    logic                  curve_ok;
    logic                  slot_ok;
    logic [ADDR_W_MAX-1:0] base;

    // Accept whenever the queue has room.
    assign in_w.ready = !q_full;
    assign push       = in_w.valid && !q_full;

    // Range checks and curve base address.
    always_comb
    begin
        bank_ok  = (32'(in_w.bank_select) < NUM_BANKS);
        curve_ok = (32'(in_w.curve_select) < CURVES_PER_BANK);
        slot_ok  = (32'(in_w.point_slot) < CURVE_WORDS);
        base     = ADDR_W_MAX'((32'(in_w.bank_select) * CURVES_PER_BANK
                               + 32'(in_w.curve_select)) * CURVE_WORDS);
        push_entry.is_lookup = (in_w.kind == KIND_LOOKUP);
        if (in_w.kind == KIND_LOOKUP)
        begin
            push_entry.in_range = bank_ok && curve_ok;
            push_entry.addr     = base;
            push_entry.data     = in_w.position;
        end
        else
        begin
            push_entry.in_range = bank_ok && curve_ok && slot_ok;
            push_entry.addr     = base + ADDR_W_MAX'(in_w.point_slot);
            push_entry.data     = in_w.table_word;
        end
    end

endmodule

// ===== design/bci_queue.sv =====
// Two-entry queue of classified words between the front and the back.
module bci_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bci_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output bci_pkg::entry_t head
);
    import bci_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty) else $error("queue popped while empty");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("queue pushed while full");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count out of range");

endmodule

// ===== design/bci_back.sv =====
// Back end: curve store, breakpoint search, multiply, serial divide and result register.
module bci_back #(
    parameter int NUM_BANKS       = bci_pkg::DEF_NUM_BANKS,
    parameter int CURVES_PER_BANK = bci_pkg::DEF_CURVES_PER_BANK,
    parameter int NUM_POINTS      = bci_pkg::DEF_NUM_POINTS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_not_empty,
    input  bci_pkg::entry_t head,
    output logic            pop,
    bci_out_if.source       out_w
);
    import bci_pkg::*;

    localparam int DEPTH = NUM_BANKS * CURVES_PER_BANK * 2 * NUM_POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(NUM_POINTS);
    localparam logic [IW-1:0] IDX_LAST = IW'(NUM_POINTS - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RUP  = 4'd1;
    localparam logic [3:0] S_CUP  = 4'd2;
    localparam logic [3:0] S_GLP  = 4'd3;
    localparam logic [3:0] S_GLV  = 4'd4;
    localparam logic [3:0] S_GUV  = 4'd5;
    localparam logic [3:0] S_MUL1 = 4'd6;
    localparam logic [3:0] S_MUL2 = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;
    logic [AW-1:0]     raddr;
    logic              we;

    logic [3:0]        state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     base_reg, base_next;
    logic signed [WORD_W-1:0] pos_reg, pos_next;
    logic signed [WORD_W-1:0] up_reg, up_next;
    logic signed [WORD_W-1:0] lp_reg, lp_next;
    logic signed [WORD_W-1:0] lv_reg, lv_next;
    logic [WORD_W-1:0] mdv_reg, mdv_next;
    logic [WORD_W-1:0] mdp_reg, mdp_next;
    logic [WORD_W-1:0] mspan_reg, mspan_next;
    logic              neg_reg, neg_next;
    logic              zero_reg, zero_next;
    logic              fault_reg, fault_next;
    logic [63:0]       quo_reg, quo_next;
    logic [WORD_W:0]   rem_reg, rem_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic              ofault_reg, ofault_next;

    logic signed [WORD_W:0] span, dv, dp;
    logic [WORD_W:0]   rem_shift;
    logic signed [41:0] sum;
    logic [LEVEL_W-1:0] final_level;
    logic              out_free;

    assign out_free           = !out_valid_reg || out_w.ready;
    assign out_w.valid        = out_valid_reg;
    assign out_w.level        = level_reg;
    assign out_w.divide_fault = ofault_reg;

    // Curve store: one write port, one registered read port.
    assign we = (state_reg == S_IDLE) && q_not_empty && !head.is_lookup && head.in_range;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[head.addr[AW-1:0]] <= head.data;
        end
        rdata_reg <= mem[raddr];
    end

    // Read address per step of the search and fetch sequence.
    always_comb
    begin
        unique case (state_reg)
            S_RUP:   raddr = base_reg + AW'(idx_reg);
            S_CUP:   raddr = base_reg + AW'(idx_reg) - AW'(1);
            S_GLP:   raddr = base_reg + AW'(NUM_POINTS) + AW'(idx_reg) - AW'(1);
            S_GLV:   raddr = base_reg + AW'(NUM_POINTS) + AW'(idx_reg);
            default: raddr = base_reg;
        endcase
    end

    // Segment differences and the final sum with clamping.
    always_comb
    begin
        span      = 33'(up_reg) - 33'(lp_reg);
        dv        = 33'($signed(rdata_reg)) - 33'(lv_reg);
        dp        = 33'(pos_reg) - 33'(lp_reg);
        rem_shift = {rem_reg[WORD_W-1:0], quo_reg[63]};
        sum       = neg_reg ? 42'(lv_reg) - $signed({2'b00, quo_reg[39:0]})
                            : 42'(lv_reg) + $signed({2'b00, quo_reg[39:0]});
        if (zero_reg || fault_reg)
        begin
            final_level = '0;
        end
        else if (quo_reg[63:40] != '0)
        begin
            final_level = neg_reg ? '0 : LEVEL_MAX;
        end
        else if (sum < 0)
        begin
            final_level = '0;
        end
        else if (sum > 42'(LEVEL_MAX))
        begin
            final_level = LEVEL_MAX;
        end
        else
        begin
            final_level = sum[LEVEL_W-1:0];
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        base_next      = base_reg;
        pos_next       = pos_reg;
        up_next        = up_reg;
        lp_next        = lp_reg;
        lv_next        = lv_reg;
        mdv_next       = mdv_reg;
        mdp_next       = mdp_reg;
        mspan_next     = mspan_reg;
        neg_next       = neg_reg;
        zero_next      = zero_reg;
        fault_next     = fault_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_w.ready;
        level_next     = level_reg;
        ofault_next    = ofault_reg;
        pop            = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    pop        = 1'b1;
                    base_next  = head.addr[AW-1:0];
                    pos_next   = head.data;
                    idx_next   = IW'(1);
                    zero_next  = 1'b0;
                    fault_next = 1'b0;
                    if (head.is_lookup)
                    begin
                        if (head.in_range)
                        begin
                            state_next = S_RUP;
                        end
                        else
                        begin
                            zero_next  = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_RUP:
            begin
                state_next = S_CUP;
            end
            S_CUP:
            begin
                if (idx_reg < IDX_LAST && !(pos_reg < $signed(rdata_reg)))
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_RUP;
                end
                else
                begin
                    up_next    = rdata_reg;
                    state_next = S_GLP;
                end
            end
            S_GLP:
            begin
                lp_next    = rdata_reg;
                state_next = S_GLV;
            end
            S_GLV:
            begin
                lv_next    = rdata_reg;
                state_next = S_GUV;
            end
            S_GUV:
            begin
                mdv_next   = dv[WORD_W] ? WORD_W'(-dv) : dv[WORD_W-1:0];
                mdp_next   = dp[WORD_W] ? WORD_W'(-dp) : dp[WORD_W-1:0];
                mspan_next = span[WORD_W] ? WORD_W'(-span) : span[WORD_W-1:0];
                neg_next   = ((dv[WORD_W] != dp[WORD_W]) != span[WORD_W])
                             && (dv != '0) && (dp != '0);
                if (span == '0)
                begin
                    fault_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                quo_next   = 64'(mdv_reg * mdp_reg[15:0]);
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                quo_next   = quo_reg + ({16'h0000, 48'(mdv_reg * mdp_reg[31:16])} << 16);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // One quotient bit per cycle, restoring.
                if (rem_shift >= {1'b0, mspan_reg})
                begin
                    rem_next = rem_shift - {1'b0, mspan_reg};
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift;
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    level_next     = final_level;
                    ofault_next    = fault_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= IW'(1);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        pos_reg   <= pos_next;
        up_reg    <= up_next;
        lp_reg    <= lp_next;
        lv_reg    <= lv_next;
        mdv_reg   <= mdv_next;
        mdp_reg   <= mdp_next;
        mspan_reg <= mspan_next;
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
        fault_reg <= fault_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        level_reg <= level_next;
        ofault_reg <= ofault_next;
    end

    a_fault_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ofault_reg) |-> (level_reg == '0))
        else $error("fault result with non-zero level");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) && (idx_reg <= IDX_LAST))
        else $error("search index out of range");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == S_IDLE))
        else $error("queue popped while busy");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == 6'd63) |=> (state_reg == S_DONE))
        else $error("divide did not finish");

endmodule

// ===== design/breakpoint_curve_interpolator.sv =====
// Top level of the breakpoint curve interpolator.
// Usage: words arrive on in_w. A write word (kind 0) loads one 32-bit entry of
// the curve store at bank, curve and slot; it gives no result. A lookup word
// (kind 1) searches the addressed curve for the first breakpoint above the
// position, interpolates on that segment and returns one result word on out_w
// with a level in 0..127 and a divide_fault flag for a zero-width segment.
// Out-of-range writes are dropped; out-of-range lookups return level 0.
// Sequence: a lookup leaves the queue, then searches the breakpoints, where
// each search step costs a store read, fetches the segment ends, multiplies
// and runs the serial divider before it reaches the result register. A write
// is stored straight from the idle state of the back end.
// Throughput: one lookup at a time; a two-word queue lets the front accept
// while the back works, and writes behind a lookup wait for it.
// Reset clears control state only; the store is undefined until written.
// When the receiver stalls, the result register holds and the back end waits
// with its next result, after which the queue fills and in_w.ready falls.
module breakpoint_curve_interpolator #(
    parameter int NUM_BANKS       = bci_pkg::DEF_NUM_BANKS,
    parameter int CURVES_PER_BANK = bci_pkg::DEF_CURVES_PER_BANK,
    parameter int NUM_POINTS      = bci_pkg::DEF_NUM_POINTS
) (
    input logic       clk,
    input logic       rst_n,
    bci_in_if.sink    in_w,
    bci_out_if.source out_w
);
    import bci_pkg::*;

    entry_t push_entry;
    entry_t head;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_not_empty;

    bci_front #(
        .NUM_BANKS       (NUM_BANKS),
        .CURVES_PER_BANK (CURVES_PER_BANK),
        .NUM_POINTS      (NUM_POINTS)
    ) u_front (
        .in_w       (in_w),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    bci_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    bci_back #(
        .NUM_BANKS       (NUM_BANKS),
        .CURVES_PER_BANK (CURVES_PER_BANK),
        .NUM_POINTS      (NUM_POINTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head        (head),
        .pop         (pop),
        .out_w       (out_w)
    );

endmodule
